// ----- hw/rtl/pixel_to_rgb888_converter_macros.svh -----
// assertion helpers used by the converter top level
`ifndef PIXEL_TO_RGB888_CONVERTER_MACROS_SVH
`define PIXEL_TO_RGB888_CONVERTER_MACROS_SVH

// same-cycle implication, checked outside reset
`define P2R_ASSERT_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define P2R_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- hw/rtl/p2r_pkg.sv -----
package p2r_pkg;

   typedef enum logic [1:0] {
      FMT_RGB   = 2'd0,
      FMT_GRAY  = 2'd1,
      FMT_BGRA  = 2'd2,
      FMT_YCBCR = 2'd3
   } pix_fmt_type;

   // q0.20 unit scale
   localparam int FRAC_BITS = 20;
   localparam logic [20:0] ONE_Q  = 21'h100000;
   localparam logic [28:0] HALF_Q = 29'h0080000;

   localparam logic signed [8:0]  Y_OFFSET = 9'sd16;
   localparam logic signed [8:0]  C_OFFSET = 9'sd128;
   localparam logic signed [13:0] Y_SCALE  = 14'sd4788;
   localparam logic signed [14:0] K_R_CR   = 15'sd7372;
   localparam logic signed [14:0] K_G_CB   = 15'sd877;
   localparam logic signed [14:0] K_G_CR   = 15'sd2191;
   localparam logic signed [14:0] K_B_CB   = 15'sd8686;

   typedef struct packed {
      logic [7:0] third_byte;
      logic [7:0] second_byte;
      logic [7:0] first_byte;
   } pix_type;

   // luma normalized and chroma weighted
   typedef struct packed {
      pix_type            pix;
      logic [20:0]        yq;
      logic signed [21:0] r_term;
      logic signed [21:0] g_cb_term;
      logic signed [21:0] g_cr_term;
      logic signed [21:0] b_term;
   } terms_type;

   // channels clamped to 0..1
   typedef struct packed {
      pix_type     pix;
      logic [20:0] r_unit;
      logic [20:0] g_unit;
      logic [20:0] b_unit;
   } units_type;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgb_type;

   function automatic logic [20:0] clamp_unit(input logic signed [22:0] v);
      logic [20:0] res;
      if (v < 0) begin
         res = '0;
      end else if (v > $signed({2'b00, ONE_Q})) begin
         res = ONE_Q;
      end else begin
         res = v[20:0];
      end
      return res;
   endfunction

endpackage

// ----- hw/rtl/p2r_weigh.sv -----
// stage 1: luma offset and scale, chroma products
module p2r_weigh (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  p2r_pkg::pix_type    in_pix,
   output logic                out_valid,
   input  logic                out_ready,
   output p2r_pkg::terms_type  out_terms
);

   logic                signed [8:0]  y_off;
   logic                signed [8:0]  cb;
   logic                signed [8:0]  cr;
   logic                signed [22:0] y_prod;
   logic                signed [23:0] r_prod;
   logic                signed [23:0] g_cb_prod;
   logic                signed [23:0] g_cr_prod;
   logic                signed [23:0] b_prod;
   p2r_pkg::terms_type  terms;
   p2r_pkg::terms_type  terms_ff;
   p2r_pkg::terms_type  terms_in;
   logic                valid_ff;
   logic                valid_in;

   always_comb begin
      y_off = $signed({1'b0, in_pix.first_byte}) - p2r_pkg::Y_OFFSET;
      cb    = $signed({1'b0, in_pix.second_byte}) - p2r_pkg::C_OFFSET;
      cr    = $signed({1'b0, in_pix.third_byte}) - p2r_pkg::C_OFFSET;
      y_prod    = 23'(y_off) * 23'(p2r_pkg::Y_SCALE);
      r_prod    = 24'(cr) * 24'(p2r_pkg::K_R_CR);
      g_cb_prod = 24'(cb) * 24'(p2r_pkg::K_G_CB);
      g_cr_prod = 24'(cr) * 24'(p2r_pkg::K_G_CR);
      b_prod    = 24'(cb) * 24'(p2r_pkg::K_B_CB);
      terms.pix       = in_pix;
      terms.yq        = p2r_pkg::clamp_unit(y_prod);
      // products stay within +-2^21
      terms.r_term    = r_prod[21:0];
      terms.g_cb_term = g_cb_prod[21:0];
      terms.g_cr_term = g_cr_prod[21:0];
      terms.b_term    = b_prod[21:0];
   end

   always_comb begin
      in_ready = !valid_ff || out_ready;
      valid_in = in_ready ? in_valid : valid_ff;
      terms_in = (in_ready && in_valid) ? terms : terms_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      terms_ff <= terms_in;
   end

   assign out_valid = valid_ff;
   assign out_terms = terms_ff;

endmodule

// ----- hw/rtl/p2r_mix.sv -----
// stage 2: channel sums and clamp to the unit range
module p2r_mix (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  p2r_pkg::terms_type  in_terms,
   output logic                out_valid,
   input  logic                out_ready,
   output p2r_pkg::units_type  out_units
);

   logic               signed [22:0] y_wide;
   logic               signed [22:0] r_sum;
   logic               signed [22:0] g_sum;
   logic               signed [22:0] b_sum;
   p2r_pkg::units_type units;
   p2r_pkg::units_type units_ff;
   p2r_pkg::units_type units_in;
   logic               valid_ff;
   logic               valid_in;

   always_comb begin
      y_wide = $signed({2'b00, in_terms.yq});
      r_sum  = y_wide + {in_terms.r_term[21], in_terms.r_term};
      g_sum  = y_wide - {in_terms.g_cb_term[21], in_terms.g_cb_term}
                      - {in_terms.g_cr_term[21], in_terms.g_cr_term};
      b_sum  = y_wide + {in_terms.b_term[21], in_terms.b_term};
      units.pix    = in_terms.pix;
      units.r_unit = p2r_pkg::clamp_unit(r_sum);
      units.g_unit = p2r_pkg::clamp_unit(g_sum);
      units.b_unit = p2r_pkg::clamp_unit(b_sum);
   end

   always_comb begin
      in_ready = !valid_ff || out_ready;
      valid_in = in_ready ? in_valid : valid_ff;
      units_in = (in_ready && in_valid) ? units : units_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      units_ff <= units_in;
   end

   assign out_valid = valid_ff;
   assign out_units = units_ff;

endmodule

// ----- hw/rtl/p2r_quant.sv -----
// stage 3: scale to 8-bit codes, format select, output register
module p2r_quant (
   input  logic                  clock,
   input  logic                  reset,
   input  p2r_pkg::pix_fmt_type  fmt,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  p2r_pkg::units_type    in_units,
   output logic                  out_valid,
   input  logic                  out_ready,
   output p2r_pkg::rgb_type      out_rgb
);

   logic             [7:0] r_code;
   logic             [7:0] g_code;
   logic             [7:0] b_code;
   p2r_pkg::rgb_type rgb;
   p2r_pkg::rgb_type rgb_ff;
   p2r_pkg::rgb_type rgb_in;
   logic             valid_ff;
   logic             valid_in;

   // (v * 255 + half) >> 20, with v * 255 = (v << 8) - v
   function automatic logic [7:0] to_code(input logic [20:0] v);
      logic [28:0] acc;
      acc = {v, 8'h00} - {8'h00, v} + p2r_pkg::HALF_Q;
      return acc[p2r_pkg::FRAC_BITS +: 8];
   endfunction

   always_comb begin
      r_code = to_code(in_units.r_unit);
      g_code = to_code(in_units.g_unit);
      b_code = to_code(in_units.b_unit);
      case (fmt)
         p2r_pkg::FMT_RGB: begin
            rgb.red   = in_units.pix.first_byte;
            rgb.green = in_units.pix.second_byte;
            rgb.blue  = in_units.pix.third_byte;
         end
         p2r_pkg::FMT_GRAY: begin
            rgb.red   = in_units.pix.first_byte;
            rgb.green = in_units.pix.first_byte;
            rgb.blue  = in_units.pix.first_byte;
         end
         p2r_pkg::FMT_BGRA: begin
            rgb.red   = in_units.pix.third_byte;
            rgb.green = in_units.pix.second_byte;
            rgb.blue  = in_units.pix.first_byte;
         end
         default: begin
            rgb.red   = r_code;
            rgb.green = g_code;
            rgb.blue  = b_code;
         end
      endcase
   end

   always_comb begin
      in_ready = !valid_ff || out_ready;
      valid_in = in_ready ? in_valid : valid_ff;
      rgb_in   = (in_ready && in_valid) ? rgb : rgb_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rgb_ff <= rgb_in;
   end

   assign out_valid = valid_ff;
   assign out_rgb   = rgb_ff;

endmodule

// ----- hw/rtl/pixel_to_rgb888_converter.sv -----
// Converts one three-byte pixel per clock to an 8-bit RGB triple. The format
// register picks rgb passthrough, gray copied to all channels, bgra with alpha
// dropped, or video-range bt.709 ycbcr computed in q0.20 fixed point (a code
// may differ by one from a double-precision result). Each item passes three
// register stages: the first stage holds the luma scale and chroma products,
// the second the channel sums and clamp, and the third is the output register
// after the 8-bit rounding. Each stage holds one item with its own valid bit,
// and a stage moves whenever the one after it is empty or drained, so a new
// item is accepted every cycle while the output is taken. Write csr_wdata
// only while no item is in flight.
`include "pixel_to_rgb888_converter_macros.svh"

module pixel_to_rgb888_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_wdata,       // pixel_format
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,       // first_byte, second_byte, third_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata        // red, green, blue
);

   p2r_pkg::pix_fmt_type fmt_ff;
   p2r_pkg::pix_fmt_type fmt_in;
   p2r_pkg::pix_type     req_pix;
   p2r_pkg::terms_type   s1_terms;
   p2r_pkg::units_type   s2_units;
   p2r_pkg::rgb_type     out_rgb;
   logic                 s1_valid;
   logic                 s1_ready;
   logic                 s2_valid;
   logic                 s2_ready;

   assign fmt_in = csr_we ? p2r_pkg::pix_fmt_type'(csr_wdata) : fmt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= p2r_pkg::FMT_RGB;
      end else begin
         fmt_ff <= fmt_in;
      end
   end

   assign req_pix = p2r_pkg::pix_type'(req_tdata);

   p2r_weigh u_weigh (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_pix    (req_pix),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_terms (s1_terms)
   );

   p2r_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_terms  (s1_terms),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_units (s2_units)
   );

   p2r_quant u_quant (
      .clock     (clock),
      .reset     (reset),
      .fmt       (fmt_ff),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_units  (s2_units),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rgb   (out_rgb)
   );

   assign rsp_tdata = out_rgb;

   // gray items leave with all three channels equal
   `P2R_ASSERT_NOW(a_gray_equal, clock, reset,
      rsp_tvalid && (fmt_ff == p2r_pkg::FMT_GRAY),
      (out_rgb.red == out_rgb.green) && (out_rgb.green == out_rgb.blue),
      "gray item with unequal channels")

   // input stalls only when every stage holds an item
   `P2R_ASSERT_NOW(a_stall_full, clock, reset,
      !req_tready, s1_valid && s2_valid && rsp_tvalid,
      "input stalled with a free stage")

   // luma at or below black level normalizes to zero
   `P2R_ASSERT_NOW(a_luma_floor, clock, reset,
      s1_valid && (s1_terms.pix.first_byte <= 8'd16), s1_terms.yq == '0,
      "luma below black level not clamped")

   // an item appears at the output only after the sum stage held one
   `P2R_ASSERT_NEXT(a_out_source, clock, reset,
      !rsp_tvalid && !s2_valid, !rsp_tvalid,
      "output item without a source")

endmodule

// ----- tb/tb_pixel_to_rgb888_converter.sv -----
module tb_pixel_to_rgb888_converter;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int UNIT        = 1 << 20;
   localparam int LUMA_BLACK  = 16;
   localparam int LUMA_GAIN   = 4788;
   localparam int CHROMA_MID  = 128;
   localparam int CR_TO_R     = 7372;
   localparam int CB_TO_G     = 877;
   localparam int CR_TO_G     = 2191;
   localparam int CB_TO_B     = 8686;
   localparam int DRAIN_WAIT  = 8;
   localparam int RANDOM_ITEMS = 1900;
   localparam int PHASES      = 8;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      p2r_pkg::pix_fmt_type fmt;
      p2r_pkg::pix_type     px;
      bit                   known;
      p2r_pkg::rgb_type     want;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   p2r_pkg::pix_fmt_type active_fmt = p2r_pkg::FMT_RGB;
   p2r_pkg::rgb_type     expected_rgb[$];
   directed_row_type     directed_rows[$];
   int                   mismatch_count = 0;
   int                   cycle_count = 0;
   bit                   steady = 1'b0;

   pixel_to_rgb888_converter i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int clip_unit(input int v);
      if (v < 0) return 0;
      if (v > UNIT) return UNIT;
      return v;
   endfunction

   // round half up from q0.20 to an 8-bit code
   function automatic logic [7:0] unit_to_code(input int v);
      longint scaled;
      scaled = (longint'(clip_unit(v)) * 255 + (UNIT >> 1)) >>> 20;
      return scaled[7:0];
   endfunction

   function automatic p2r_pkg::rgb_type convert_pixel(input p2r_pkg::pix_fmt_type fmt,
                                                      input p2r_pkg::pix_type px);
      p2r_pkg::rgb_type o;
      int      luma;
      int      cb;
      int      cr;
      case (fmt)
         p2r_pkg::FMT_RGB: begin
            o.red = px.first_byte; o.green = px.second_byte; o.blue = px.third_byte;
         end
         p2r_pkg::FMT_GRAY: begin
            o.red = px.first_byte; o.green = px.first_byte; o.blue = px.first_byte;
         end
         p2r_pkg::FMT_BGRA: begin
            o.red = px.third_byte; o.green = px.second_byte; o.blue = px.first_byte;
         end
         default: begin
            luma = clip_unit((int'(px.first_byte) - LUMA_BLACK) * LUMA_GAIN);
            cb = int'(px.second_byte) - CHROMA_MID;
            cr = int'(px.third_byte) - CHROMA_MID;
            o.red   = unit_to_code(luma + CR_TO_R * cr);
            o.green = unit_to_code(luma - CB_TO_G * cb - CR_TO_G * cr);
            o.blue  = unit_to_code(luma + CB_TO_B * cb);
         end
      endcase
      return o;
   endfunction

   function automatic p2r_pkg::pix_type pix(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
      p2r_pkg::pix_type p;
      p.first_byte = a; p.second_byte = b; p.third_byte = c;
      return p;
   endfunction

   function automatic p2r_pkg::rgb_type rgb(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
      p2r_pkg::rgb_type o;
      o.red = r; o.green = g; o.blue = b;
      return o;
   endfunction

   // corner values turn up often so the clamps get exercised
   function automatic logic [7:0] pick_byte();
      logic [7:0] corner;
      case ($urandom_range(5))
         0: corner = 8'h00;
         1: corner = 8'hFF;
         2: corner = 8'h10;
         3: corner = 8'hEB;
         4: corner = 8'h80;
         default: corner = 8'h7F;
      endcase
      if ($urandom_range(4) == 0) return corner;
      return 8'($urandom);
   endfunction

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 23);
   end

   always @(posedge clock) begin
      p2r_pkg::rgb_type want;
      p2r_pkg::rgb_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_rgb.size() == 0) begin
            $error("result item with nothing expected: %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = expected_rgb.pop_front();
            if (got.red !== want.red) begin
               $error("red: expected %0d, got %0d", want.red, got.red);
               mismatch_count++;
            end
            if (got.green !== want.green) begin
               $error("green: expected %0d, got %0d", want.green, got.green);
               mismatch_count++;
            end
            if (got.blue !== want.blue) begin
               $error("blue: expected %0d, got %0d", want.blue, got.blue);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic wait_drained();
      while (expected_rgb.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic set_format(input p2r_pkg::pix_fmt_type fmt);
      req_tvalid <= 1'b0;
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= fmt;
      @(posedge clock);
      csr_we     <= 1'b0;
      active_fmt = fmt;
   endtask

   // leaves tvalid high so back-to-back items need no gap
   task automatic send_pixel(input p2r_pkg::pix_type px, input bit known,
                             input p2r_pkg::rgb_type want);
      // idle cycles come in runs, each one added with odds of about 23 in a hundred
      while (!steady && $urandom_range(99) < 23) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      @(posedge clock);
      while (!(req_tvalid && req_tready)) @(posedge clock);
      expected_rgb.insert(expected_rgb.size(),
                          known ? want : convert_pixel(active_fmt, px));
   endtask

   initial begin
      p2r_pkg::pix_fmt_type fmt;
      int          sent;
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_wdata  = p2r_pkg::FMT_RGB;
      req_tvalid = 1'b0;
      req_tdata  = '0;

      directed_rows = '{
         // reset format is rgb passthrough
         '{p2r_pkg::FMT_RGB,   pix(8'h00, 8'h00, 8'h00), 1'b1, rgb(8'h00, 8'h00, 8'h00)},
         '{p2r_pkg::FMT_RGB,   pix(8'hFF, 8'hFF, 8'hFF), 1'b1, rgb(8'hFF, 8'hFF, 8'hFF)},
         '{p2r_pkg::FMT_RGB,   pix(8'h12, 8'h34, 8'h56), 1'b1, rgb(8'h12, 8'h34, 8'h56)},
         '{p2r_pkg::FMT_RGB,   pix(8'hA5, 8'h5A, 8'hC3), 1'b1, rgb(8'hA5, 8'h5A, 8'hC3)},
         // gray ignores the other two bytes
         '{p2r_pkg::FMT_GRAY,  pix(8'h00, 8'hFF, 8'hFF), 1'b1, rgb(8'h00, 8'h00, 8'h00)},
         '{p2r_pkg::FMT_GRAY,  pix(8'hFF, 8'h00, 8'h00), 1'b1, rgb(8'hFF, 8'hFF, 8'hFF)},
         '{p2r_pkg::FMT_GRAY,  pix(8'h80, 8'h12, 8'h34), 1'b1, rgb(8'h80, 8'h80, 8'h80)},
         '{p2r_pkg::FMT_BGRA,  pix(8'h11, 8'h22, 8'h33), 1'b1, rgb(8'h33, 8'h22, 8'h11)},
         '{p2r_pkg::FMT_BGRA,  pix(8'hFF, 8'h00, 8'h80), 1'b1, rgb(8'h80, 8'h00, 8'hFF)},
         // luma at and beyond video range, neutral chroma
         '{p2r_pkg::FMT_YCBCR, pix(8'h10, 8'h80, 8'h80), 1'b1, rgb(8'h00, 8'h00, 8'h00)},
         '{p2r_pkg::FMT_YCBCR, pix(8'hEB, 8'h80, 8'h80), 1'b1, rgb(8'hFF, 8'hFF, 8'hFF)},
         '{p2r_pkg::FMT_YCBCR, pix(8'h00, 8'h80, 8'h80), 1'b1, rgb(8'h00, 8'h00, 8'h00)},
         '{p2r_pkg::FMT_YCBCR, pix(8'hFF, 8'h80, 8'h80), 1'b1, rgb(8'hFF, 8'hFF, 8'hFF)},
         // mid gray, chroma pushing channels into the clamps, then one rgb item
         '{p2r_pkg::FMT_YCBCR, pix(8'h7E, 8'h80, 8'h80), 1'b0, rgb(8'h00, 8'h00, 8'h00)},
         '{p2r_pkg::FMT_YCBCR, pix(8'hEB, 8'hFF, 8'h00), 1'b0, rgb(8'h00, 8'h00, 8'h00)},
         '{p2r_pkg::FMT_YCBCR, pix(8'h10, 8'h00, 8'hFF), 1'b0, rgb(8'h00, 8'h00, 8'h00)},
         '{p2r_pkg::FMT_YCBCR, pix(8'hEB, 8'h00, 8'hFF), 1'b0, rgb(8'h00, 8'h00, 8'h00)},
         '{p2r_pkg::FMT_YCBCR, pix(8'h10, 8'hFF, 8'h00), 1'b0, rgb(8'h00, 8'h00, 8'h00)},
         '{p2r_pkg::FMT_YCBCR, pix(8'h80, 8'hFF, 8'hFF), 1'b0, rgb(8'h00, 8'h00, 8'h00)},
         '{p2r_pkg::FMT_YCBCR, pix(8'h80, 8'h00, 8'h00), 1'b0, rgb(8'h00, 8'h00, 8'h00)},
         '{p2r_pkg::FMT_YCBCR, pix(8'h51, 8'h5A, 8'hF0), 1'b0, rgb(8'h00, 8'h00, 8'h00)},
         '{p2r_pkg::FMT_RGB,   pix(8'h01, 8'h80, 8'hFE), 1'b1, rgb(8'h01, 8'h80, 8'hFE)}
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].fmt != active_fmt) set_format(directed_rows[i].fmt);
         send_pixel(directed_rows[i].px, directed_rows[i].known, directed_rows[i].want);
      end

      sent = 0;
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: fmt = p2r_pkg::FMT_YCBCR;
            1: fmt = p2r_pkg::FMT_GRAY;
            2: fmt = p2r_pkg::FMT_BGRA;
            3: fmt = p2r_pkg::FMT_RGB;
            4: fmt = p2r_pkg::FMT_YCBCR;
            default: fmt = p2r_pkg::pix_fmt_type'($urandom_range(3));
         endcase
         set_format(fmt);
         for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
            // one long stretch with both sides streaming
            steady = (sent >= 700 && sent < 1000);
            send_pixel(pix(pick_byte(), pick_byte(), pick_byte()), 1'b0,
                       rgb(8'h00, 8'h00, 8'h00));
            sent++;
         end
      end
      steady = 1'b0;

      req_tvalid <= 1'b0;
      wait_drained();
      if (mismatch_count == 0 && expected_rgb.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/p2r_pkg.sv
hw/rtl/p2r_weigh.sv
hw/rtl/p2r_mix.sv
hw/rtl/p2r_quant.sv
hw/rtl/pixel_to_rgb888_converter.sv
tb/tb_pixel_to_rgb888_converter.sv
